// ===== rtl/qdr_pkg.sv =====
// ----------------------------------------------------------------------------
// qdr_pkg: shared types and helpers of the quantized dense/recurrent layer
// Register map, channel words, queue entry and Q-format alignment function.
// ----------------------------------------------------------------------------
`default_nettype none

package qdr_pkg;

    localparam int QDR_QDEPTH = 4;
    localparam int QDR_QPTR_W = 2;

    typedef enum logic [2:0] {
        REG_MAIN_LENGTH      = 3'd0,
        REG_REC_LENGTH       = 3'd1,
        REG_ROW_COUNT        = 3'd2,
        REG_BIAS_ENABLE      = 3'd3,
        REG_KERNEL_FRAC_BITS = 3'd4,
        REG_BIAS_FRAC_BITS   = 3'd5,
        REG_MAIN_FRAC_BITS   = 3'd6,
        REG_REC_FRAC_BITS    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [10:0] main_length;
        logic [10:0] rec_length;
        logic [15:0] row_count;
        logic        bias_enable;
        logic [3:0]  kernel_frac_bits;
        logic [4:0]  bias_frac_bits;
        logic [3:0]  main_frac_bits;
        logic [3:0]  rec_frac_bits;
    } t_cfg;

    typedef struct packed {
        logic signed [7:0]  weight;
        logic signed [15:0] sample_value;
        logic signed [15:0] bias_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pre_activation;
        logic               last_row;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_MAC     = 2'd0,
        KIND_SEG_END = 2'd1,
        KIND_ROW_END = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [23:0] product;
        logic signed [15:0] bias;
        logic               rec_mode;
        logic               last_row;
    } t_entry;

    // saturating left shift for s > 0, arithmetic right shift for s < 0
    // left amounts used here never exceed 15
    function automatic logic signed [63:0] q_align(input logic signed [63:0] x,
                                                   input logic signed [5:0]  s);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        logic signed [63:0] c;
        logic [5:0]         ra;
        logic [3:0]         la;
        ra = 6'(-s);
        la = s[3:0];
        hi = $signed(64'h7FFF_FFFF_FFFF_FFFF >> la);
        lo = ~hi;
        c  = x;
        if (x > hi) begin
            c = hi;
        end
        if (x < lo) begin
            c = lo;
        end
        if (s < 0) begin
            return x >>> ra;
        end
        return c <<< la;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/qdr_front.sv =====
// ----------------------------------------------------------------------------
// qdr_front: term intake and classification
// Counts terms per segment and rows per layer, forms the product and tags
// each word as plain term, end of main segment or end of row.
// ----------------------------------------------------------------------------
`default_nettype none

module qdr_front import qdr_pkg::*; #(
    parameter int MAX_TERMS = 1024
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in_data,
    output logic          o_in_ready,
    input  wire logic     i_queue_full,
    output logic          o_push,
    output t_entry        o_entry
);

    localparam logic [15:0] MAX_TERMS_W = 16'(MAX_TERMS);

    logic [10:0] r_term_cnt;
    logic [10:0] n_term_cnt;
    logic        r_rec_seg;
    logic        n_rec_seg;
    logic [15:0] r_row_cnt;
    logic [15:0] n_row_cnt;

    logic [10:0] mlen;
    logic [10:0] rlen;
    logic [10:0] term_inc;
    logic [15:0] row_inc;
    logic        row_end;

    assign o_in_ready = !i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    always_comb begin
        mlen = i_cfg.main_length;
        if (mlen == 11'd0) begin
            mlen = 11'd1;
        end
        if ({5'd0, mlen} > MAX_TERMS_W) begin
            mlen = MAX_TERMS_W[10:0];
        end
        rlen = i_cfg.rec_length;
        if ({5'd0, rlen} > MAX_TERMS_W) begin
            rlen = MAX_TERMS_W[10:0];
        end
    end

    always_comb begin
        term_inc   = r_term_cnt + 11'd1;
        row_inc    = r_row_cnt + 16'd1;
        n_term_cnt = term_inc;
        n_rec_seg  = r_rec_seg;
        n_row_cnt  = r_row_cnt;
        row_end    = 1'b0;

        o_entry.product  = 24'(i_in_data.weight * i_in_data.sample_value);
        o_entry.bias     = i_in_data.bias_value;
        o_entry.rec_mode = r_rec_seg;
        o_entry.kind     = KIND_MAC;
        o_entry.last_row = 1'b0;

        if (!r_rec_seg) begin
            if (term_inc >= mlen) begin
                n_term_cnt = 11'd0;
                if (rlen == 11'd0) begin
                    row_end = 1'b1;
                end else begin
                    o_entry.kind = KIND_SEG_END;
                    n_rec_seg    = 1'b1;
                end
            end
        end else if (term_inc >= rlen) begin
            n_term_cnt = 11'd0;
            n_rec_seg  = 1'b0;
            row_end    = 1'b1;
        end

        if (row_end) begin
            o_entry.kind = KIND_ROW_END;
            n_row_cnt    = row_inc;
            if (row_inc >= i_cfg.row_count) begin
                o_entry.last_row = 1'b1;
                n_row_cnt        = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_cnt <= 11'd0;
            r_rec_seg  <= 1'b0;
            r_row_cnt  <= 16'd0;
        end else if (o_push) begin
            r_term_cnt <= n_term_cnt;
            r_rec_seg  <= n_rec_seg;
            r_row_cnt  <= n_row_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qdr_queue.sv =====
// ----------------------------------------------------------------------------
// qdr_queue: short first-word-fall-through queue
// Decouples term intake from the accumulator and row finishing pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module qdr_queue import qdr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_entry      o_head
);

    t_entry                r_mem [QDR_QDEPTH];
    logic [QDR_QPTR_W-1:0] r_wr_ptr;
    logic [QDR_QPTR_W-1:0] r_rd_ptr;
    logic [QDR_QPTR_W:0]   r_count;
    logic [QDR_QPTR_W:0]   n_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == (QDR_QPTR_W + 1)'(QDR_QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qdr_back.sv =====
// ----------------------------------------------------------------------------
// qdr_back: accumulator and row finishing pipeline
// Accumulates products, realigns between segments, then aligns the sum,
// adds the bias, rescales to Q15 and clamps over four registered stages.
// ----------------------------------------------------------------------------
`default_nettype none

module qdr_back import qdr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_head_valid,
    input  wire t_entry i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output t_out_item   o_out_data
);

    logic signed [63:0] r_acc;
    logic signed [63:0] n_acc;
    logic               r_pend;
    logic               n_pend;

    logic               r_s1_valid;
    logic signed [63:0] r_s1_sum;
    logic signed [15:0] r_s1_bias;
    logic               r_s1_rec;
    logic               r_s1_last;

    logic               r_s2_valid;
    logic signed [63:0] r_s2_sum;
    logic signed [63:0] r_s2_bias;
    logic [4:0]         r_s2_qs;
    logic               r_s2_last;

    logic               r_s3_valid;
    logic signed [63:0] r_s3_sum;
    logic [4:0]         r_s3_qs;
    logic               r_s3_last;

    logic               r_s4_valid;
    logic signed [63:0] r_s4_sum;
    logic               r_s4_last;

    logic               r_out_valid;
    t_out_item          r_out_data;

    logic               out_free;
    logic               s4_free;
    logic               s3_free;
    logic               s2_free;
    logic               s1_free;
    logic signed [63:0] prod_ext;
    logic signed [63:0] mac_sum;
    logic signed [5:0]  seg_shift;

    logic [3:0]         in_frac;
    logic [4:0]         q;
    logic [4:0]         qs;
    logic [4:0]         lead;
    logic signed [5:0]  bias_shift;
    logic [5:0]         bias_rsh;
    logic signed [63:0] bias_ext;
    logic signed [63:0] bias_al;
    logic signed [5:0]  final_shift;

    assign out_free = !r_out_valid || i_out_ready;
    assign s4_free  = !r_s4_valid || out_free;
    assign s3_free  = !r_s3_valid || s4_free;
    assign s2_free  = !r_s2_valid || s3_free;
    assign s1_free  = !r_s1_valid || s2_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign prod_ext  = 64'(i_head.product);
    assign mac_sum   = r_acc + prod_ext;
    assign seg_shift = $signed({2'b00, i_cfg.rec_frac_bits})
                     - $signed({2'b00, i_cfg.main_frac_bits});

    // no word is popped while the realignment after the main segment is pending
    assign o_pop = i_head_valid && !r_pend && (i_head.kind != KIND_ROW_END || s1_free);

    always_comb begin
        n_acc  = r_acc;
        n_pend = r_pend;
        if (r_pend) begin
            n_acc  = q_align(r_acc, seg_shift);
            n_pend = 1'b0;
        end else if (o_pop) begin
            case (i_head.kind)
                KIND_MAC: begin
                    n_acc = mac_sum;
                end
                KIND_SEG_END: begin
                    n_acc  = mac_sum;
                    n_pend = 1'b1;
                end
                KIND_ROW_END: begin
                    n_acc = '0;
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
        end
    end

    // sum format and bias alignment for the word in stage one
    always_comb begin
        in_frac    = r_s1_rec ? i_cfg.rec_frac_bits : i_cfg.main_frac_bits;
        q          = {1'b0, in_frac} + {1'b0, i_cfg.kernel_frac_bits};
        qs         = (i_cfg.bias_enable && q < 5'd15) ? 5'd15 : q;
        lead       = qs - q;
        bias_shift = $signed({1'b0, qs}) - $signed({1'b0, i_cfg.bias_frac_bits});
        bias_rsh   = 6'(-bias_shift);
        bias_ext   = 64'(r_s1_bias);
        if (!i_cfg.bias_enable) begin
            bias_al = '0;
        end else if (bias_shift < 0) begin
            bias_al = bias_ext >>> bias_rsh;
        end else begin
            bias_al = bias_ext <<< bias_shift[4:0];
        end
    end

    assign final_shift = 6'sd15 - $signed({1'b0, r_s3_qs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_pend      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_pend <= n_pend;
            if (s1_free) begin
                r_s1_valid <= o_pop && (i_head.kind == KIND_ROW_END);
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_free) begin
                r_s3_valid <= r_s2_valid;
            end
            if (s4_free) begin
                r_s4_valid <= r_s3_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_sum  <= mac_sum;
            r_s1_bias <= i_head.bias;
            r_s1_rec  <= i_head.rec_mode;
            r_s1_last <= i_head.last_row;
        end
        if (s2_free) begin
            r_s2_sum  <= q_align(r_s1_sum, $signed({1'b0, lead}));
            r_s2_bias <= bias_al;
            r_s2_qs   <= qs;
            r_s2_last <= r_s1_last;
        end
        if (s3_free) begin
            r_s3_sum  <= r_s2_sum + r_s2_bias;
            r_s3_qs   <= r_s2_qs;
            r_s3_last <= r_s2_last;
        end
        if (s4_free) begin
            r_s4_sum  <= q_align(r_s3_sum, final_shift);
            r_s4_last <= r_s3_last;
        end
        if (out_free) begin
            if (r_s4_sum > 64'sd2147483647) begin
                r_out_data.pre_activation <= 32'sh7FFF_FFFF;
            end else if (r_s4_sum < -64'sd2147483648) begin
                r_out_data.pre_activation <= 32'sh8000_0000;
            end else begin
                r_out_data.pre_activation <= r_s4_sum[31:0];
            end
            r_out_data.last_row <= r_s4_last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/quantized_dense_recurrent_layer.sv =====
// ----------------------------------------------------------------------------
// quantized_dense_recurrent_layer: int8 x int16 dense / recurrent row engine
// Input words are weight/value terms, main segment first then recurrent
// segment; the row's last word carries the bias. One output word per row
// holds the Q15 pre-activation clamped to int32 and a last-row flag.
// Both channels are valid/ready. One term is taken per cycle while the queue
// has room; the front end counts and tags terms into a four-word queue, the
// back end accumulates. In a row with a recurrent segment the back end holds
// off popping while it realigns the sum between segments. From the row's last
// word to its result the sum passes accumulate, align, bias add, Q15 shift and
// clamp register. When the receiver stalls, the finishing stages and the queue
// fill and then the input ready drops; nothing is lost. Reset clears the
// counters, the queue and the sum, and loads the register defaults. The user
// must see that registers are written through the plain write port only while
// the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_dense_recurrent_layer import qdr_pkg::*; #(
    parameter int MAX_TERMS = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data
);

    t_cfg   r_cfg;
    logic   queue_full;
    logic   push;
    t_entry push_entry;
    logic   head_valid;
    t_entry head;
    logic   pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.main_length      <= 11'd1;
            r_cfg.rec_length       <= 11'd0;
            r_cfg.row_count        <= 16'd1;
            r_cfg.bias_enable      <= 1'b1;
            r_cfg.kernel_frac_bits <= 4'd7;
            r_cfg.bias_frac_bits   <= 5'd15;
            r_cfg.main_frac_bits   <= 4'd15;
            r_cfg.rec_frac_bits    <= 4'd15;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MAIN_LENGTH:      r_cfg.main_length      <= i_cfg_data[10:0];
                REG_REC_LENGTH:       r_cfg.rec_length       <= i_cfg_data[10:0];
                REG_ROW_COUNT:        r_cfg.row_count        <= i_cfg_data;
                REG_BIAS_ENABLE:      r_cfg.bias_enable      <= i_cfg_data[0];
                REG_KERNEL_FRAC_BITS: r_cfg.kernel_frac_bits <= i_cfg_data[3:0];
                REG_BIAS_FRAC_BITS:   r_cfg.bias_frac_bits   <= i_cfg_data[4:0];
                REG_MAIN_FRAC_BITS:   r_cfg.main_frac_bits   <= i_cfg_data[3:0];
                REG_REC_FRAC_BITS:    r_cfg.rec_frac_bits    <= i_cfg_data[3:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    qdr_front #(
        .MAX_TERMS (MAX_TERMS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_ready   (o_in_ready),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    qdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    qdr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire
